@@ hdl/mctt_pkg.sv @@
// Shared types and constants for the MIDI clock tempo tracker.
// No dependencies; used by mctt_div and the top level.
package mctt_pkg;

    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 42;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    localparam int unsigned TICKS_PER_QUARTER = 24;

    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_SYNCING = 2'd1;
    localparam logic [1:0] MODE_RUNNING = 2'd2;

    localparam logic [9:0]  BPM_MAX   = 10'd1023;
    localparam logic [41:0] BPM_NUM2  = 42'd1280000000000;
    localparam logic [27:0] GAIN_NUM  = 28'd143360000;
    localparam logic [27:0] GAIN_BASE = 28'd2560;
    localparam logic [47:0] OFF_MUL   = 48'd15000000000;
    localparam logic [4:0]  CHANGE_LIMIT = 5'd24;

endpackage

@@ hdl/mctt_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mctt_pkg for widths and the status struct.
module mctt_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mctt_pkg::DIV_NUM_W-1:0]  num,
    input  logic [mctt_pkg::DIV_DEN_W-1:0]  den,
    output logic [mctt_pkg::DIV_NUM_W-1:0]  quo,
    output mctt_pkg::div_stat_t             stat
);

    localparam int NW = mctt_pkg::DIV_NUM_W;
    localparam int DW = mctt_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] shf_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_hold_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          qbit;

    always_comb
    begin
        trial = {rem_reg, shf_reg[NW-1]};
        qbit  = (trial >= {1'b0, den_hold_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shf_reg      <= num;
            rem_reg      <= '0;
            den_hold_reg <= den;
        end
        else if (busy_reg)
        begin
            // shift one numerator bit in, subtract when it fits
            rem_reg <= qbit ? DW'(trial - {1'b0, den_hold_reg}) : trial[DW-1:0];
            shf_reg <= {shf_reg[NW-2:0], qbit};
        end
    end

    assign quo       = shf_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hdl/midi_clock_tempo_tracker_top.sv @@
// MIDI clock tempo tracker, top level.
// Depends on mctt_pkg and mctt_div.
//
// Takes one beat at a time: in_stall is high from acceptance until the result is
// loaded into the output register. A song-position beat goes straight to the output
// stage. A sync tick does the same when the tempo is zero, else it first runs a serial
// multiply and an offset division. A clock tick runs through the shared bit-serial
// divider: a tempo division unless the filtered interval is zero, and an inlier adds
// two more divisions before it. Each division costs one cycle per quotient bit of
// the 50-bit divider.
module midi_clock_tempo_tracker_top #(
    parameter int TIME_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [47:0] timestamp_ns,
    input  logic [13:0] song_position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  bpm_estimate,
    output logic [9:0]  committed_tempo,
    output logic [47:0] reference_time_ns,
    output logic        reference_updated,
    output logic [31:0] clock_count,
    output logic        quarter_note
);

    localparam int TW = TIME_BITS;
    localparam int NW = mctt_pkg::DIV_NUM_W;
    localparam int DW = mctt_pkg::DIV_DEN_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIFF   = 4'd1;
    localparam logic [3:0] S_CMP    = 4'd2;
    localparam logic [3:0] S_OUTL   = 4'd3;
    localparam logic [3:0] S_GAIN   = 4'd4;
    localparam logic [3:0] S_STEPS  = 4'd5;
    localparam logic [3:0] S_STEPW  = 4'd6;
    localparam logic [3:0] S_BPM    = 4'd7;
    localparam logic [3:0] S_BPMW   = 4'd8;
    localparam logic [3:0] S_COMMIT = 4'd9;
    localparam logic [3:0] S_MUL    = 4'd10;
    localparam logic [3:0] S_OFFS   = 4'd11;
    localparam logic [3:0] S_OFFW   = 4'd12;
    localparam logic [3:0] S_FINISH = 4'd13;

    logic [3:0]    state_reg;
    logic [1:0]    mode_reg;
    logic [TW-1:0] last_reg;
    logic [TW-1:0] ts_reg;
    logic [39:0]   filt_reg;
    logic [4:0]    score_reg;
    logic [9:0]    tempo_reg;
    logic [9:0]    held_reg;
    logic [4:0]    chg_reg;
    logic [31:0]   cc_reg;
    logic [4:0]    qmod_reg;
    logic [13:0]   spos_reg;
    logic [47:0]   ref_reg;
    logic          upd_reg;
    logic [31:0]   raw_reg;
    logic [39:0]   diff_reg;
    logic          dir_reg;
    logic [27:0]   gain_reg;
    logic [47:0]   macc_reg;
    logic [47:0]   mcand_reg;
    logic [13:0]   mplr_reg;
    logic [3:0]    mcnt_reg;

    logic          out_valid_reg;
    logic [9:0]    o_bpm_reg;
    logic [9:0]    o_held_reg;
    logic [47:0]   o_ref_reg;
    logic          o_upd_reg;
    logic [31:0]   o_cc_reg;
    logic          o_qn_reg;

    logic                 div_start;
    logic [NW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic [NW-1:0]        div_quo;
    mctt_pkg::div_stat_t  div_stat;

    logic [63:0]   t64;
    logic [TW-1:0] t_w;
    logic [TW-1:0] dt;
    logic [63:0]   dt64;
    logic [31:0]   raw_sat;
    logic [39:0]   r40;
    logic [42:0]   diff5;
    logic          inlier;
    logic [63:0]   ts64;
    logic [63:0]   off64;
    logic          accept;
    logic          load_out;
    logic [4:0]    score_up;
    logic [31:0]   pos32;

    mctt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    always_comb
    begin
        t64     = {16'b0, timestamp_ns};
        t_w     = t64[TW-1:0];
        dt      = t_w - last_reg;
        dt64    = 64'(dt);
        raw_sat = (|dt64[63:32]) ? 32'hFFFF_FFFF : dt64[31:0];
        r40     = {raw_reg, 8'b0};
        diff5   = {1'b0, diff_reg, 2'b0} + {3'b0, diff_reg};
        inlier  = (raw_reg != 32'd0) && (diff5 < {3'b0, filt_reg});
        ts64    = 64'(ts_reg);
        off64   = 64'(div_quo);
        accept  = in_valid && (state_reg == S_IDLE);
        load_out = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);
        score_up = score_reg + 5'd10;
        pos32   = 32'(song_position);
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_CMP:
            begin
                div_start = inlier;
                div_num   = NW'(mctt_pkg::GAIN_NUM);
                div_den   = DW'(raw_reg);
            end
            S_STEPS:
            begin
                div_start = 1'b1;
                div_num   = NW'({diff_reg, 8'b0});
                div_den   = DW'(gain_reg);
            end
            S_BPM:
            begin
                div_start = (filt_reg != 40'd0);
                div_num   = NW'(mctt_pkg::BPM_NUM2) + NW'(filt_reg);
                div_den   = DW'({filt_reg, 1'b0});
            end
            S_OFFS:
            begin
                div_start = 1'b1;
                div_num   = NW'({macc_reg, 1'b0}) + NW'(tempo_reg);
                div_den   = DW'({tempo_reg, 1'b0});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= mctt_pkg::MODE_STOPPED;
            last_reg  <= '0;
            filt_reg  <= '0;
            score_reg <= '0;
            tempo_reg <= '0;
            held_reg  <= '0;
            chg_reg   <= '0;
            cc_reg    <= '0;
            qmod_reg  <= '0;
            spos_reg  <= '0;
            ref_reg   <= '0;
            upd_reg   <= 1'b0;
            mcnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_type)
                        begin
                            mode_reg  <= mctt_pkg::MODE_SYNCING;
                            spos_reg  <= song_position;
                            cc_reg    <= (pos32 << 2) + (pos32 << 1);
                            qmod_reg  <= 5'(song_position[1:0]) * 5'd6;
                            upd_reg   <= 1'b0;
                            state_reg <= S_FINISH;
                        end
                        else if (mode_reg == mctt_pkg::MODE_SYNCING)
                        begin
                            if (tempo_reg == 10'd0)
                            begin
                                ref_reg   <= '0;
                                last_reg  <= t_w;
                                mode_reg  <= mctt_pkg::MODE_RUNNING;
                                upd_reg   <= 1'b1;
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                mcnt_reg  <= 4'd14;
                                state_reg <= S_MUL;
                            end
                        end
                        else
                        begin
                            cc_reg <= cc_reg + 32'd1;
                            // counter wraps at 2^32, which is not a multiple of 24
                            if (cc_reg == 32'hFFFF_FFFF)
                                qmod_reg <= '0;
                            else if (qmod_reg == 5'(mctt_pkg::TICKS_PER_QUARTER - 1))
                                qmod_reg <= '0;
                            else
                                qmod_reg <= qmod_reg + 5'd1;
                            last_reg  <= t_w;
                            upd_reg   <= 1'b0;
                            state_reg <= S_DIFF;
                        end
                    end
                end
                S_DIFF:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    state_reg <= inlier ? S_GAIN : S_OUTL;
                end
                S_OUTL:
                begin
                    // too many net outliers: snap the filter to the raw interval
                    if (score_up > 5'd20)
                    begin
                        filt_reg  <= r40;
                        score_reg <= '0;
                    end
                    else
                        score_reg <= score_up;
                    state_reg <= S_BPM;
                end
                S_GAIN:
                begin
                    if (div_stat.done)
                        state_reg <= S_STEPS;
                end
                S_STEPS:
                begin
                    state_reg <= S_STEPW;
                end
                S_STEPW:
                begin
                    if (div_stat.done)
                    begin
                        filt_reg <= dir_reg ? filt_reg + div_quo[39:0]
                                            : filt_reg - div_quo[39:0];
                        if (score_reg != 5'd0)
                            score_reg <= score_reg - 5'd1;
                        state_reg <= S_BPM;
                    end
                end
                S_BPM:
                begin
                    if (filt_reg == 40'd0)
                    begin
                        tempo_reg <= mctt_pkg::BPM_MAX;
                        state_reg <= S_COMMIT;
                    end
                    else
                        state_reg <= S_BPMW;
                end
                S_BPMW:
                begin
                    if (div_stat.done)
                    begin
                        tempo_reg <= (|div_quo[NW-1:10]) ? mctt_pkg::BPM_MAX : div_quo[9:0];
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    if (held_reg != tempo_reg)
                    begin
                        if (chg_reg >= mctt_pkg::CHANGE_LIMIT)
                        begin
                            held_reg <= tempo_reg;
                            chg_reg  <= '0;
                        end
                        else
                            chg_reg <= chg_reg + 5'd1;
                    end
                    state_reg <= S_FINISH;
                end
                S_MUL:
                begin
                    mcnt_reg <= mcnt_reg - 4'd1;
                    if (mcnt_reg == 4'd1)
                        state_reg <= S_OFFS;
                end
                S_OFFS:
                begin
                    state_reg <= S_OFFW;
                end
                S_OFFW:
                begin
                    if (div_stat.done)
                    begin
                        ref_reg   <= (ts64 > off64) ? 48'(ts64 - off64) : 48'd0;
                        last_reg  <= ts_reg;
                        mode_reg  <= mctt_pkg::MODE_RUNNING;
                        upd_reg   <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ts_reg    <= t_w;
            raw_reg   <= raw_sat;
            macc_reg  <= '0;
            mcand_reg <= mctt_pkg::OFF_MUL;
            mplr_reg  <= spos_reg;
        end
        if (state_reg == S_DIFF)
        begin
            dir_reg  <= (r40 > filt_reg);
            diff_reg <= (r40 > filt_reg) ? r40 - filt_reg : filt_reg - r40;
        end
        if (state_reg == S_GAIN && div_stat.done)
            gain_reg <= mctt_pkg::GAIN_BASE + div_quo[27:0];
        if (state_reg == S_MUL)
        begin
            // one multiplier bit per cycle
            if (mplr_reg[0])
                macc_reg <= macc_reg + mcand_reg;
            mcand_reg <= {mcand_reg[46:0], 1'b0};
            mplr_reg  <= {1'b0, mplr_reg[13:1]};
        end
        if (load_out)
        begin
            o_bpm_reg  <= tempo_reg;
            o_held_reg <= held_reg;
            o_ref_reg  <= ref_reg;
            o_upd_reg  <= upd_reg;
            o_cc_reg   <= cc_reg;
            o_qn_reg   <= (qmod_reg == 5'd0);
        end
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign bpm_estimate      = o_bpm_reg;
    assign committed_tempo   = o_held_reg;
    assign reference_time_ns = o_ref_reg;
    assign reference_updated = o_upd_reg;
    assign clock_count       = o_cc_reg;
    assign quarter_note      = o_qn_reg;

endmodule

@@ tb/midi_clock_tempo_tracker_top_tb.sv @@
// Testbench for the MIDI clock tempo tracker top level.
// Depends on mctt_pkg and midi_clock_tempo_tracker_top; predicts each result in-line.
module midi_clock_tempo_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [9:0]  bpm;
        logic [9:0]  held;
        logic [47:0] ref_time;
        logic        ref_upd;
        logic [31:0] count;
        logic        quarter;
    } tempo_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [47:0] timestamp_ns = '0;
    logic [13:0] song_position = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [9:0]  bpm_estimate;
    logic [9:0]  committed_tempo;
    logic [47:0] reference_time_ns;
    logic        reference_updated;
    logic [31:0] clock_count;
    logic        quarter_note;

    midi_clock_tempo_tracker_top uut (.*);

    // predictor state
    logic [1:0]  mode_q;
    logic [47:0] last_tick_q;
    logic [39:0] filt_q;
    int unsigned score_q;
    logic [9:0]  tempo_q;
    logic [9:0]  held_q;
    int unsigned change_q;
    logic [31:0] count_q;
    logic [13:0] sync_pos_q;
    logic [47:0] ref_q;

    tempo_beat_t expected_beats[$];
    int          errors = 0;
    int          beats_checked = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [47:0] now_ns = '0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [9:0] bpm_of(logic [39:0] f);
        logic [63:0] q;
        if (f == 0)
            return mctt_pkg::BPM_MAX;
        q = (64'd1280000000000 + 64'(f)) / (64'd2 * 64'(f));
        return (q > 64'd1023) ? mctt_pkg::BPM_MAX : q[9:0];
    endfunction

    function automatic tempo_beat_t predict_tempo(logic rq, logic [47:0] t, logic [13:0] pos);
        tempo_beat_t b;
        logic        upd;
        logic [63:0] dt, raw, r, f, diff, gq, stp, num, off;
        upd = 1'b0;
        if (rq)
        begin
            mode_q = mctt_pkg::MODE_SYNCING;
            sync_pos_q = pos;
            count_q = 32'(pos) * 32'd6;
        end
        else if (mode_q == mctt_pkg::MODE_SYNCING)
        begin
            if (tempo_q == 10'd0)
                ref_q = '0;
            else
            begin
                num = 64'(sync_pos_q) * 64'd15000000000;
                off = (64'd2 * num + 64'(tempo_q)) / (64'd2 * 64'(tempo_q));
                ref_q = (64'(t) > off) ? 48'(64'(t) - off) : '0;
            end
            last_tick_q = t;
            mode_q = mctt_pkg::MODE_RUNNING;
            upd = 1'b1;
        end
        else
        begin
            count_q = count_q + 32'd1;
            dt = 64'(48'(t - last_tick_q));
            raw = (dt > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : dt;
            r = raw << 8;
            f = 64'(filt_q);
            diff = (r > f) ? r - f : f - r;
            if (raw != 0 && diff * 5 < f)
            begin
                gq = 64'd2560 + (64'd143360000 / raw);
                stp = (diff * 64'd256) / gq;
                f = (r > f) ? f + stp : f - stp;
                if (score_q >= 1)
                    score_q--;
            end
            else
            begin
                score_q += 10;
                if (score_q > 20)
                begin
                    f = r;
                    score_q = 0;
                end
            end
            filt_q = f[39:0];
            tempo_q = bpm_of(filt_q);
            last_tick_q = t;
            if (held_q != tempo_q)
            begin
                change_q++;
                if (change_q > 24)
                begin
                    held_q = tempo_q;
                    change_q = 0;
                end
            end
        end
        b.bpm = tempo_q;
        b.held = held_q;
        b.ref_time = ref_q;
        b.ref_upd = upd;
        b.count = count_q;
        b.quarter = (count_q % mctt_pkg::TICKS_PER_QUARTER) == 0;
        return b;
    endfunction

    // valid stays up after acceptance until the next beat or an idle cycle drops it
    task automatic send_beat(logic rq, logic [47:0] t, logic [13:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        timestamp_ns <= t;
        song_position <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_beats.push_back(predict_tempo(rq, t, pos));
    endtask

    task automatic send_tick(int unsigned dt);
        now_ns = now_ns + 48'(dt);
        send_beat(1'b0, now_ns, 14'($urandom));
    endtask

    // receiver stall, driven at the edge
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        tempo_beat_t e, a;
        if (rst_n && out_valid && !out_stall)
        begin
            a = '{bpm_estimate, committed_tempo, reference_time_ns, reference_updated,
                  clock_count, quarter_note};
            if (expected_beats.size() == 0)
            begin
                $display("%0t unexpected beat: actual %h", $time, a);
                errors++;
            end
            else
            begin
                e = expected_beats.pop_front();
                beats_checked++;
                if (a != e)
                begin
                    errors++;
                    $display("%0t mismatch bpm exp %0d act %0d held exp %0d act %0d",
                             $time, e.bpm, a.bpm, e.held, a.held);
                    $display("    ref exp %0d act %0d upd exp %0b act %0b", e.ref_time,
                             a.ref_time, e.ref_upd, a.ref_upd);
                    $display("    count exp %0d act %0d quarter exp %0b act %0b",
                             e.count, a.count, e.quarter, a.quarter);
                end
            end
        end
    end

    task automatic test_directed();
        send_tick(0);                        // zero interval: outlier
        send_tick(20833333);                 // 120 bpm
        send_beat(1'b1, '0, 14'h3FFF);       // sync prepare, max position
        send_beat(1'b0, 48'hFFFF_FFFF_FFFF, 14'h3FFF);
        now_ns = 48'hFFFF_FFFF_FFFF;
        for (int i = 0; i < 8; i++)
            send_tick(20833333);             // wraps time
        send_tick(1);
        send_tick(32'hFFFF_FFFF);
        send_beat(1'b0, now_ns - 48'd5, '0); // huge wrapped interval, saturates
        now_ns = now_ns - 48'd5;
        send_beat(1'b1, 48'h1234, 14'd0);
        send_tick(100);                      // sync tick at position 0
        for (int i = 0; i < 6; i++)
            send_tick(100);                  // tempo saturates
        send_beat(1'b1, '0, 14'd5);
        send_tick(3);                        // sync tick at position 5
    endtask

    task automatic test_random(int n);
        int unsigned base;
        for (int i = 0; i < n; i++)
        begin
            base = $urandom_range(5000000, 60000000);
            case ($urandom_range(19))
                0: send_beat(1'b1, 48'($urandom) << 16 | 48'($urandom), 14'($urandom));
                1:
                begin
                    now_ns = 48'({$urandom, $urandom});
                    send_beat(1'b0, now_ns, 14'($urandom));
                end
                2: send_tick($urandom_range(0, 1000));
                3: send_tick(base * 2);
                default:
                begin
                    // steady run with small jitter, enough to reach commits
                    for (int k = 0; k < 30 && i < n; k++, i++)
                        send_tick(base + $urandom_range(0, base / 50));
                end
            endcase
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        mode_q = mctt_pkg::MODE_STOPPED; last_tick_q = '0; filt_q = '0; score_q = 0;
        tempo_q = '0; held_q = '0; change_q = 0; count_q = '0;
        sync_pos_q = '0; ref_q = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain();
        send_idle_pct = 33; recv_stall_pct = 49;
        test_random(480);
        send_idle_pct = 49; recv_stall_pct = 33;
        test_random(480);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(480);
        drain();
        $display("covered ticks, syncs, outliers, time wrap and tempo commits: %0d beats",
                 beats_checked);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("status: fail");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/mctt_pkg.sv
hdl/mctt_div.sv
hdl/midi_clock_tempo_tracker_top.sv
tb/midi_clock_tempo_tracker_top_tb.sv
